### sv/calculator_token_lexer_macros.svh
// Assertion macros for the calculator token lexer checker.
// Needs signals named clock and reset in the scope where a macro is used.
`ifndef CALCULATOR_TOKEN_LEXER_MACROS_SVH
`define CALCULATOR_TOKEN_LEXER_MACROS_SVH

// same-cycle implication
`define CTLEX_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CTLEX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/ctlex_pkg.sv
// Shared types and constants of the calculator token lexer.
// No dependencies; used by every module of the block.
package ctlex_pkg;

   localparam int MaxResults = 4;
   localparam int ResCountW  = $clog2(MaxResults + 1);
   localparam int ResIdxW    = $clog2(MaxResults);

   typedef logic [7:0] char_type;
   typedef logic [1:0] part_type;

   typedef enum logic [4:0] {
      M_IDLE,
      M_PAIR,
      M_MINUS,
      M_STR,
      M_VAR,
      M_RSTART,
      M_RINT,
      M_RFRAC,
      M_REXP,
      M_REXPS,
      M_REXPD,
      M_RDONE,
      M_CXMID,
      M_CXEND
   } mode_type;

   // token characters caused by one input item
   typedef struct packed {
      logic [ResCountW-1:0]             count;
      logic [MaxResults-1:0][7:0]       chars;
      logic [MaxResults-1:0]            lasts;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam part_type CpNone   = 2'd0;
   localparam part_type CpFirst  = 2'd1;
   localparam part_type CpSecond = 2'd2;

   localparam char_type ChNul    = 8'h00;
   localparam char_type ChHt     = 8'h09;
   localparam char_type ChCr     = 8'h0D;
   localparam char_type ChSpace  = 8'h20;
   localparam char_type ChBang   = 8'h21;
   localparam char_type ChQuote  = 8'h22;
   localparam char_type ChLParen = 8'h28;
   localparam char_type ChRParen = 8'h29;
   localparam char_type ChPlus   = 8'h2B;
   localparam char_type ChMinus  = 8'h2D;
   localparam char_type ChDot    = 8'h2E;
   localparam char_type ChSlash  = 8'h2F;
   localparam char_type Ch0      = 8'h30;
   localparam char_type Ch9      = 8'h39;
   localparam char_type ChColon  = 8'h3A;
   localparam char_type ChLt     = 8'h3C;
   localparam char_type ChEq     = 8'h3D;
   localparam char_type ChGt     = 8'h3E;
   localparam char_type ChAt     = 8'h40;
   localparam char_type ChUpA    = 8'h41;
   localparam char_type ChUpE    = 8'h45;
   localparam char_type ChUpZ    = 8'h5A;
   localparam char_type ChUnder  = 8'h5F;
   localparam char_type ChLowA   = 8'h61;
   localparam char_type ChLowC   = 8'h63;
   localparam char_type ChLowE   = 8'h65;
   localparam char_type ChLowL   = 8'h6C;
   localparam char_type ChLowR   = 8'h72;
   localparam char_type ChLowZ   = 8'h7A;

endpackage

### sv/ctlex_front.sv
// Front end of the lexer: accepts text characters, runs the token state machine
// and hands the token characters of each item to the queue. Uses ctlex_pkg.
module ctlex_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  ctlex_pkg::char_type         in_char,
   input  logic                        in_end,
   output logic                        push_valid,
   output ctlex_pkg::bundle_type       push_data,
   input  ctlex_pkg::queue_status_type q_status
);
   import ctlex_pkg::*;

   // longest chain of re-dispatches of one character
   localparam int LexSteps = 5;

   typedef enum logic [2:0] {
      S_MODE,
      S_START,
      S_RNUM,
      S_CXMID,
      S_CXEND
   } step_type;

   typedef struct packed {
      mode_type   md;
      part_type   cp;
      logic       sd;
      char_type   hc;
      logic       hv;
      bundle_type res;
   } work_type;

   mode_type mode_ff, mode_in;
   part_type cp_ff, cp_in;
   logic     sd_ff, sd_in;
   char_type hc_ff, hc_in;
   logic     hv_ff, hv_in;
   work_type lex_in;

   logic accept;
   logic is_end;
   logic c_ws, c_dig, c_alp, c_sfx, c_exp, c_sign, c_lead, pair_hit;

   function automatic work_type emit_ch(work_type w, char_type ch, logic last);
      work_type r;
      r = w;
      if (r.res.count < ResCountW'(MaxResults)) begin
         r.res.chars[r.res.count[ResIdxW-1:0]] = ch;
         r.res.lasts[r.res.count[ResIdxW-1:0]] = last;
         r.res.count = r.res.count + ResCountW'(1);
      end
      return r;
   endfunction

   function automatic work_type to_idle(work_type w);
      work_type r;
      r = w;
      r.hv = 1'b0;
      r.md = M_IDLE;
      r.cp = CpNone;
      r.sd = 1'b0;
      return r;
   endfunction

   function automatic work_type push(work_type w, char_type ch);
      work_type r;
      r = w;
      if (r.hv) r = emit_ch(r, r.hc, 1'b0);
      r.hc = ch;
      r.hv = 1'b1;
      return r;
   endfunction

   function automatic work_type finish(work_type w, char_type ch);
      work_type r;
      r = w;
      if (r.hv) r = emit_ch(r, r.hc, 1'b0);
      r = emit_ch(r, ch, 1'b1);
      r = to_idle(r);
      return r;
   endfunction

   function automatic work_type close_tok(work_type w);
      work_type r;
      r = w;
      if (r.hv) r = emit_ch(r, r.hc, 1'b1);
      r = to_idle(r);
      return r;
   endfunction

   function automatic work_type suffix(work_type w, char_type ch);
      work_type r;
      r = w;
      if (r.cp == CpNone) begin
         r = finish(r, ch);
      end else begin
         r = push(r, ch);
         r.md = M_RDONE;
      end
      return r;
   endfunction

   assign is_end = in_end || (in_char == ChNul);
   assign c_ws   = in_char inside {ChSpace, [ChHt:ChCr]};
   assign c_dig  = in_char inside {[Ch0:Ch9]};
   assign c_alp  = in_char inside {[ChLowA:ChLowZ], [ChUpA:ChUpZ], ChUnder};
   assign c_sfx  = in_char inside {ChLowL, ChLowR, ChLowC};
   assign c_exp  = in_char inside {ChLowE, ChUpE};
   assign c_sign = in_char inside {ChPlus, ChMinus};
   assign c_lead = in_char inside {ChAt, ChLt, ChGt, ChBang, ChSlash};
   assign pair_hit = ((hc_ff == ChAt) && (in_char inside {ChAt, ChBang}))
                  || ((hc_ff inside {ChLt, ChGt, ChBang}) && (in_char == ChEq))
                  || ((hc_ff == ChSlash) && (in_char == ChSlash));

   // next state and token characters of the current item
   always_comb begin : lex_next
      work_type w;
      step_type st;
      logic     go;
      logic     ne_req;
      logic     ne_raw;
      w.md  = mode_ff;
      w.cp  = cp_ff;
      w.sd  = sd_ff;
      w.hc  = hc_ff;
      w.hv  = hv_ff;
      w.res = '0;
      st     = S_MODE;
      go     = 1'b0;
      ne_req = 1'b0;
      ne_raw = 1'b0;
      if (is_end) begin
         if (mode_ff == M_STR) begin
            w = finish(w, ChQuote);
         end else if ((mode_ff != M_IDLE) && (cp_ff != CpNone)) begin
            w = finish(w, ChRParen);
         end else begin
            w = close_tok(w);
         end
         w.hc = '0;
      end else begin
         if (mode_ff inside {M_RSTART, M_RINT, M_RFRAC, M_REXP, M_REXPS, M_REXPD,
                             M_RDONE}) begin
            st = S_RNUM;
         end else if (mode_ff == M_IDLE) begin
            st = S_START;
         end else begin
            st = S_MODE;
         end
         go = 1'b1;
         for (int i = 0; i < LexSteps; i++) begin
            if (go) begin
               go     = 1'b0;
               ne_req = 1'b0;
               ne_raw = 1'b0;
               case (st)
                  S_START: begin
                     if (!c_ws) begin
                        if (in_char == ChLParen) begin
                           w = push(w, in_char);
                           w.md = M_RSTART;
                           w.cp = CpFirst;
                           w.sd = 1'b0;
                        end else if (c_lead) begin
                           w = push(w, in_char);
                           w.md = M_PAIR;
                        end else if (in_char == ChMinus) begin
                           w = push(w, in_char);
                           w.md = M_MINUS;
                        end else if (in_char == ChQuote) begin
                           w = push(w, in_char);
                           w.md = M_STR;
                        end else if (c_dig) begin
                           w = push(w, in_char);
                           w.md = M_RINT;
                           w.cp = CpNone;
                           w.sd = 1'b1;
                        end else if (in_char == ChDot) begin
                           w = push(w, in_char);
                           w.md = M_RFRAC;
                           w.cp = CpNone;
                           w.sd = 1'b0;
                        end else if (c_alp) begin
                           w = push(w, in_char);
                           w.md = M_VAR;
                        end else begin
                           w = finish(w, in_char);
                        end
                     end
                  end
                  S_MODE: begin
                     case (w.md)
                        M_PAIR: begin
                           if (pair_hit) begin
                              w = finish(w, in_char);
                           end else begin
                              w = close_tok(w);
                              st = S_START;
                              go = 1'b1;
                           end
                        end
                        M_MINUS: begin
                           if (c_dig) begin
                              w = push(w, in_char);
                              w.md = M_RINT;
                              w.cp = CpNone;
                              w.sd = 1'b1;
                           end else begin
                              w = close_tok(w);
                              st = S_START;
                              go = 1'b1;
                           end
                        end
                        M_STR: begin
                           if (in_char == ChQuote) w = finish(w, in_char);
                           else w = push(w, in_char);
                        end
                        M_VAR: begin
                           if (c_alp || c_dig) begin
                              w = push(w, in_char);
                           end else if ((in_char == ChAt) || (in_char == ChColon)) begin
                              w = finish(w, in_char);
                           end else begin
                              w = close_tok(w);
                              st = S_START;
                              go = 1'b1;
                           end
                        end
                        M_CXMID: begin
                           if (!c_ws) begin
                              st = S_CXMID;
                              go = 1'b1;
                           end
                        end
                        M_CXEND: begin
                           if (!c_ws) begin
                              st = S_CXEND;
                              go = 1'b1;
                           end
                        end
                        default: begin
                           w = to_idle(w);
                           st = S_START;
                           go = 1'b1;
                        end
                     endcase
                  end
                  S_CXMID: begin
                     if (in_char == ChRParen) begin
                        w = finish(w, in_char);
                     end else begin
                        w = push(w, ChSpace);
                        w.cp = CpSecond;
                        w.sd = 1'b0;
                        w.md = M_RSTART;
                        st = S_RNUM;
                        go = 1'b1;
                     end
                  end
                  S_CXEND: begin
                     if (in_char == ChRParen) begin
                        w = finish(w, in_char);
                     end else begin
                        w = finish(w, ChRParen);
                        st = S_START;
                        go = 1'b1;
                     end
                  end
                  S_RNUM: begin
                     if ((w.md == M_RSTART) && c_sign) begin
                        w = push(w, in_char);
                        w.md = M_RINT;
                     end else if (!((w.md == M_RSTART) && c_ws)) begin
                        if (w.md == M_RSTART) w.md = M_RINT;
                        case (w.md)
                           M_RINT: begin
                              if (c_dig) begin
                                 w = push(w, in_char);
                                 w.sd = 1'b1;
                              end else if (in_char == ChDot) begin
                                 w = push(w, in_char);
                                 w.md = M_RFRAC;
                              end else if (c_exp && w.sd) begin
                                 w = push(w, in_char);
                                 w.md = M_REXP;
                              end else if (c_sfx) begin
                                 w = suffix(w, in_char);
                              end else begin
                                 ne_req = 1'b1;
                              end
                           end
                           M_RFRAC: begin
                              if (c_dig) begin
                                 w = push(w, in_char);
                                 w.sd = 1'b1;
                              end else if (c_exp && w.sd) begin
                                 w = push(w, in_char);
                                 w.md = M_REXP;
                              end else if (c_sfx) begin
                                 w = suffix(w, in_char);
                              end else begin
                                 ne_req = 1'b1;
                              end
                           end
                           M_REXP: begin
                              if (c_sign) begin
                                 w = push(w, in_char);
                                 w.md = M_REXPS;
                              end else if (c_dig) begin
                                 w = push(w, in_char);
                                 w.md = M_REXPD;
                              end else begin
                                 ne_req = 1'b1;
                                 ne_raw = 1'b1;
                              end
                           end
                           M_REXPS: begin
                              if (c_dig) begin
                                 w = push(w, in_char);
                                 w.md = M_REXPD;
                              end else begin
                                 ne_req = 1'b1;
                                 ne_raw = 1'b1;
                              end
                           end
                           M_REXPD: begin
                              if (c_dig) begin
                                 w = push(w, in_char);
                              end else if (c_sfx) begin
                                 w = suffix(w, in_char);
                              end else begin
                                 ne_req = 1'b1;
                              end
                           end
                           default: begin
                              ne_req = 1'b1;
                           end
                        endcase
                     end
                  end
                  default: begin
                     go = 1'b0;
                  end
               endcase
               // end of a real part
               if (ne_req) begin
                  if (w.cp == CpFirst) begin
                     if (!ne_raw && c_ws) begin
                        w.md = M_CXMID;
                     end else begin
                        st = S_CXMID;
                        go = 1'b1;
                     end
                  end else if (w.cp == CpSecond) begin
                     if (!ne_raw && c_ws) begin
                        w.md = M_CXEND;
                     end else begin
                        st = S_CXEND;
                        go = 1'b1;
                     end
                  end else begin
                     w = close_tok(w);
                     st = S_START;
                     go = 1'b1;
                  end
               end
            end
         end
      end
      lex_in = w;
   end

   assign mode_in = lex_in.md;
   assign cp_in   = lex_in.cp;
   assign sd_in   = lex_in.sd;
   assign hc_in   = lex_in.hc;
   assign hv_in   = lex_in.hv;

   always_comb begin
      in_ready   = !q_status.full;
      accept     = in_valid && !q_status.full;
      push_valid = accept && (lex_in.res.count != '0);
      push_data  = lex_in.res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         cp_ff   <= CpNone;
         sd_ff   <= 1'b0;
         hc_ff   <= '0;
         hv_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         cp_ff   <= cp_in;
         sd_ff   <= sd_in;
         hc_ff   <= hc_in;
         hv_ff   <= hv_in;
      end
   end

endmodule

### sv/ctlex_fifo.sv
// Queue of token character groups between lexer front end and output stage.
// Uses ctlex_pkg for the group and status types.
module ctlex_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  ctlex_pkg::bundle_type       push_data,
   input  logic                        pop,
   output ctlex_pkg::bundle_type       head,
   output ctlex_pkg::queue_status_type status
);
   import ctlex_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   bundle_type            mem_ff [DEPTH];
   bundle_type            head_ff;
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       count_ff, count_in;

   function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
      return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push_valid ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) count_in = count_ff + CntW'(1);
      else if (!push_valid && pop) count_in = count_ff - CntW'(1);
      head         = head_ff;
      status.full  = (count_ff == CntW'(DEPTH));
      status.empty = (count_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (push_valid) mem_ff[wr_ptr_ff] <= push_data;
   end

   // head entry, taken straight from the write side when it is written now
   always_ff @(posedge clock) begin
      if (push_valid && (wr_ptr_ff == rd_ptr_in)) head_ff <= push_data;
      else head_ff <= mem_ff[rd_ptr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/ctlex_back.sv
// Output stage: takes token character groups from the queue and sends them
// one item at a time on the result stream. Uses ctlex_pkg.
module ctlex_back (
   input  logic                        clock,
   input  logic                        reset,
   input  ctlex_pkg::bundle_type       head,
   input  ctlex_pkg::queue_status_type q_status,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output ctlex_pkg::char_type         rsp_tdata,
   output logic                        rsp_tlast
);
   import ctlex_pkg::*;

   bundle_type          cur_ff, cur_in;
   logic [ResIdxW-1:0]  idx_ff, idx_in;
   logic                busy_ff, busy_in;
   logic                take;
   logic                at_end;
   logic                load;

   always_comb begin
      take    = busy_ff && rsp_tready;
      at_end  = ({1'b0, idx_ff} + ResCountW'(1)) == cur_ff.count;
      load    = (!busy_ff || (take && at_end)) && !q_status.empty;
      pop     = load;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      cur_in  = cur_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
         cur_in  = head;
      end else if (take && at_end) begin
         busy_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + ResIdxW'(1);
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = cur_ff.chars[idx_ff];
   assign rsp_tlast  = cur_ff.lasts[idx_ff];

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

endmodule

### sv/calculator_token_lexer.sv
// Calculator token lexer, top level; instantiates ctlex_front, ctlex_fifo and
// ctlex_back and uses ctlex_pkg.
//
// Text arrives one character per req item (req_tuser high ends the text and
// flushes the pending token). Each character is classified combinationally
// by the front end and may cause zero to four token characters, which go as
// one group into a queue of QUEUE_DEPTH groups; the output stage sends one
// token character per cycle while rsp_tready is high, rsp_tlast marking the
// end of a token. A new character is taken every cycle while the queue has
// room, so the input runs at one character per cycle as long as characters
// cause on average no more than one token character each; beyond that the
// output port sets the pace. A character whose lastness needs the next one
// is held back until that next character (or end of text) arrives.
module calculator_token_lexer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_char
   input  logic       req_tuser,   // [0] text_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] token_char
   output logic       rsp_tlast
);
   import ctlex_pkg::*;

   logic             push_valid;
   bundle_type       push_data;
   bundle_type       q_head;
   logic             q_pop;
   queue_status_type q_status;

   ctlex_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_char    (req_tdata),
      .in_end     (req_tuser),
      .push_valid (push_valid),
      .push_data  (push_data),
      .q_status   (q_status)
   );

   ctlex_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   ctlex_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .q_status   (q_status),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### sv/ctlex_checker.sv
// Port-level checks for the calculator token lexer, bound to the top level.
// Uses calculator_token_lexer_macros.svh and ctlex_pkg.
`include "calculator_token_lexer_macros.svh"

module ctlex_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);
   import ctlex_pkg::*;

   // input ready and output idle straight after reset
   `CTLEX_ASSERT_IMPLY(a_reset_clear, $past(reset), !rsp_tvalid && req_tready, "not clear after reset")

   `CTLEX_ASSERT_NEXT(a_stall_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled item changed")

   // a NUL never reaches a token
   `CTLEX_ASSERT_IMPLY(a_no_nul, rsp_tvalid, rsp_tdata != ChNul, "NUL in token")

   // supplied space always sits inside a complex number
   `CTLEX_ASSERT_IMPLY(a_last_not_space, rsp_tvalid && rsp_tlast, rsp_tdata != ChSpace, "token ends in space")

endmodule

bind calculator_token_lexer ctlex_checker u_ctlex_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
